### rtl/mlsc_pkg.sv
// ----------------------------------------------------------------------------
// mlsc_pkg: shared definitions of the companding sample codec
// Field widths, action codes and the segment tables used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mlsc_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int CODE_W    = 8;
   localparam int SHIFT_W   = 18;                 // sample bits below the 14-bit value
   localparam int VALUE_W   = SAMPLE_W - SHIFT_W; // 14-bit signed value
   localparam int MAG_W     = VALUE_W - 1;        // 13-bit magnitude
   localparam int SEG_COUNT = 8;
   localparam int SEG_W     = 3;
   localparam int IVL_W     = 4;
   localparam int IVL_MAX   = 15;
   localparam int SEG_LAST  = SEG_COUNT - 1;

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   // Upper magnitude threshold of each segment, smallest magnitudes first.
   localparam logic [MAG_W-1:0] SEG_TOP [SEG_COUNT] = '{
      13'd30, 13'd94, 13'd222, 13'd478, 13'd990, 13'd2014, 13'd4062, 13'd8190
   };

   // Quantizer step of each segment. All but the last are powers of two.
   localparam logic [MAG_W-1:0] SEG_STEP [SEG_COUNT] = '{
      13'd2, 13'd4, 13'd8, 13'd16, 13'd32, 13'd64, 13'd128, 13'd258
   };

   localparam logic [CODE_W-1:0] SIGN_MASK = 8'h80;

endpackage

`default_nettype wire

### rtl/mu_law_style_sample_codec.sv
// ----------------------------------------------------------------------------
// mu_law_style_sample_codec: mu-law style companding codec
// Converts 32-bit samples to 8-bit codes and back, direction chosen per request.
// ----------------------------------------------------------------------------
// An accepted request passes through the input register and then the result
// register before it is presented on the rsp_ ports.
// Throughput: one request per clock cycle; the input register and the result
// register are the only stages, with the codec logic between them.
// Reset: a synchronous reset clears both stage valid flags and holds busy high
// while reset is asserted. The receiver cannot stall, so busy is low otherwise.
`default_nettype none

module mu_law_style_sample_codec
   import mlsc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_action,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   input  wire logic [CODE_W-1:0]          req_code_in,
   output logic                            rsp_strobe,
   output logic [CODE_W-1:0]               rsp_code_out,
   output logic signed [SAMPLE_W-1:0]      rsp_sample_out
);

   // Input stage: the captured request waiting for the codec logic.
   logic                       stg_vld_ff;
   logic                       stg_vld_in;
   action_type                 stg_action_ff;
   logic signed [SAMPLE_W-1:0] stg_sample_ff;
   logic [CODE_W-1:0]          stg_code_ff;

   // Result stage: one result shown for exactly one cycle.
   logic                       rsp_vld_ff;
   logic [CODE_W-1:0]          rsp_code_ff;
   logic [CODE_W-1:0]          rsp_code_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_in;

   logic accept;

   // Nothing downstream can push back, so the block only refuses requests
   // while it is being reset.
   assign busy   = reset;
   assign accept = start && !busy;

   assign stg_vld_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
         rsp_vld_ff <= stg_vld_ff;
      end
   end

   // Payload registers load unconditionally; the valid flags qualify them.
   always_ff @(posedge clock) begin
      stg_action_ff <= action_type'(req_action);
      stg_sample_ff <= req_sample_in;
      stg_code_ff   <= req_code_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   mlsc_datapath u_datapath (
      .action     (stg_action_ff),
      .sample_in  (stg_sample_ff),
      .code_in    (stg_code_ff),
      .code_out   (rsp_code_in),
      .sample_out (rsp_sample_in)
   );

   assign rsp_strobe     = rsp_vld_ff;
   assign rsp_code_out   = rsp_code_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // An accepted request reaches the result ports through both stage registers.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted request did not produce a result");

   // No result appears without a request in the input stage.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !stg_vld_ff |=> !rsp_strobe)
      else $error("result strobe without a captured request");

   // Each result carries only one direction: the unused field is zero.
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_code_out == '0 || rsp_sample_out == '0))
      else $error("result drives both code and sample");

endmodule

`default_nettype wire

### rtl/mlsc_datapath.sv
// ----------------------------------------------------------------------------
// mlsc_datapath: encode and decode logic of the companding codec
// Combinational conversion between a sample and an 8-bit code for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module mlsc_datapath
   import mlsc_pkg::*;
(
   input  wire action_type                action,
   input  wire logic signed [SAMPLE_W-1:0] sample_in,
   input  wire logic [CODE_W-1:0]         code_in,
   output logic [CODE_W-1:0]              code_out,
   output logic signed [SAMPLE_W-1:0]     sample_out
);

   logic [VALUE_W-1:0] value;
   logic               enc_sign;
   logic [MAG_W-1:0]   enc_mag;
   logic [CODE_W-1:0]  enc_code;
   logic [SAMPLE_W-1:0] dec_sample;

   assign value    = sample_in[SAMPLE_W-1:SHIFT_W];
   assign enc_sign = ~value[VALUE_W-1];
   assign enc_mag  = value[VALUE_W-1] ? ~value[MAG_W-1:0] : value[MAG_W-1:0];

   // Encoder: the first segment whose threshold covers the magnitude wins.
   always_comb begin
      logic             found;
      logic [SEG_W-1:0] seg;
      logic [IVL_W-1:0] ivl;
      logic [IVL_W-1:0] ivl_seg [SEG_COUNT];
      logic [MAG_W-1:0] diff;
      found = 1'b0;
      seg   = '0;
      for (int k = 0; k < SEG_COUNT; k++) begin
         diff = SEG_TOP[k] - enc_mag;
         if (k < SEG_LAST) begin
            ivl_seg[k] = IVL_W'(diff >> (k + 1));
         end else begin
            // The top step is not a power of two: count the step multiples.
            ivl_seg[k] = '0;
            for (int i = 1; i <= IVL_MAX; i++) begin
               if (diff >= MAG_W'(int'(SEG_STEP[k]) * i)) begin
                  ivl_seg[k] = IVL_W'(i);
               end
            end
         end
         if (!found && (enc_mag <= SEG_TOP[k])) begin
            found = 1'b1;
            seg   = SEG_W'(k);
         end
      end
      ivl = ivl_seg[seg];
      if (found) begin
         enc_code = {enc_sign, ~seg, ivl};
      end else begin
         // The largest magnitude lies beyond every segment: sign bit only.
         enc_code = enc_sign ? SIGN_MASK : '0;
      end
   end

   // Decoder: rebuild the magnitude from the segment top and the interval.
   always_comb begin
      logic [SEG_W-1:0]   seg;
      logic [MAG_W-1:0]   mag;
      logic [VALUE_W-1:0] dec_value;
      seg       = ~code_in[6:4];
      mag       = SEG_TOP[seg] - MAG_W'(SEG_STEP[seg] * MAG_W'(code_in[IVL_W-1:0]));
      dec_value = code_in[CODE_W-1] ? {1'b0, mag} : ~{1'b0, mag};
      dec_sample = {dec_value, {SHIFT_W{1'b0}}};
   end

   always_comb begin
      unique case (action)
         ACT_ENCODE: begin
            code_out   = enc_code;
            sample_out = '0;
         end
         ACT_DECODE: begin
            code_out   = '0;
            sample_out = dec_sample;
         end
         default: begin
            code_out   = '0;
            sample_out = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### tb/codec_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// codec_result_checker: result checker of the companding sample codec
// Watches the request and result ports, computes the code or sample due for
// each accepted request and compares every result with the oldest one due.
// ----------------------------------------------------------------------------

module codec_result_checker
   import mlsc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic                       req_action,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   input  wire logic [CODE_W-1:0]          req_code_in,
   input  wire logic                       rsp_strobe,
   input  wire logic [CODE_W-1:0]          rsp_code_out,
   input  wire logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output int                              mismatch_count,
   output int                              pending_results
);

   // Segment thresholds and steps, smallest magnitudes first.
   localparam int SEGMENT_TOP [8]  = '{30, 94, 222, 478, 990, 2014, 4062, 8190};
   localparam int SEGMENT_STEP [8] = '{2, 4, 8, 16, 32, 64, 128, 258};

   typedef struct {
      logic [CODE_W-1:0]   code;
      logic [SAMPLE_W-1:0] sample;
   } codec_result_type;

   codec_result_type due_results [$];
   int               errors = 0;

   function automatic logic [CODE_W-1:0] companded_code(logic [SAMPLE_W-1:0] smp);
      logic [13:0]       value;
      int                mag;
      logic [CODE_W-1:0] code;
      logic              hit;
      value = smp[31:18];
      // A negative value maps to -v-1, which is 8191 minus its low 13 bits.
      if (!value[13]) begin
         code = SIGN_MASK;
         mag  = int'(value[12:0]);
      end else begin
         code = '0;
         mag  = 8191 - int'(value[12:0]);
      end
      hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (!hit && mag <= SEGMENT_TOP[k]) begin
            hit  = 1'b1;
            code = code | CODE_W'(((7 - k) << 4) + (SEGMENT_TOP[k] - mag) / SEGMENT_STEP[k]);
         end
      end
      return code;
   endfunction

   function automatic logic [SAMPLE_W-1:0] expanded_sample(logic [CODE_W-1:0] code);
      int                  k;
      logic [SAMPLE_W-1:0] mag;
      k   = 7 - int'(code[6:4]);
      mag = SAMPLE_W'(SEGMENT_TOP[k] - SEGMENT_STEP[k] * int'(code[3:0]));
      return code[7] ? (mag << 18) : ((~mag) << 18);
   endfunction

   always @(posedge clock) begin : watch
      codec_result_type want;
      codec_result_type fresh;
      if (!reset && rsp_strobe) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: code_out %0h sample_out %0h",
                   rsp_code_out, rsp_sample_out);
            errors++;
         end else begin
            want = due_results.pop_front();
            if (rsp_code_out !== want.code) begin
               $error("code_out: expected %0h, actual %0h", want.code, rsp_code_out);
               errors++;
            end
            if (rsp_sample_out !== want.sample) begin
               $error("sample_out: expected %0h, actual %0h", want.sample, rsp_sample_out);
               errors++;
            end
         end
      end
      if (!reset && start && !busy) begin
         if (action_type'(req_action) == ACT_ENCODE) begin
            fresh.code   = companded_code(req_sample_in);
            fresh.sample = '0;
         end else begin
            fresh.code   = '0;
            fresh.sample = expanded_sample(req_code_in);
         end
         due_results.push_back(fresh);
      end
      mismatch_count  <= errors;
      pending_results <= due_results.size();
   end

endmodule

### tb/tb_mu_law_style_sample_codec.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mu_law_style_sample_codec: testbench of the companding sample codec
// Drives directed and random encode and decode requests with random gaps and
// lets a separate checker compute and compare every result.
// ----------------------------------------------------------------------------

module tb_mu_law_style_sample_codec;
   import mlsc_pkg::*;

   // The watchdog gives up after this many cycles with no request taken and
   // no result shown.
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_COUNT = 500;
   // The input and result registers lie between acceptance and the result; the rest is spare.
   localparam int DRAIN_CYCLES = 6;

   // All inputs hold known values from time zero.
   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       start         = 1'b0;
   logic                       req_action    = ACT_ENCODE;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic [CODE_W-1:0]          req_code_in   = '0;

   logic                       busy;
   logic                       rsp_strobe;
   logic [CODE_W-1:0]          rsp_code_out;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;

   int mismatch_count;
   int pending_results;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   mu_law_style_sample_codec DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_sample_in  (req_sample_in),
      .req_code_in    (req_code_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_code_out   (rsp_code_out),
      .rsp_sample_out (rsp_sample_out)
   );

   codec_result_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_sample_in   (req_sample_in),
      .req_code_in     (req_code_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_code_out    (rsp_code_out),
      .rsp_sample_out  (rsp_sample_out),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // The watchdog restarts whenever a request is accepted or a result shows.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Places a 14-bit value in the top bits of a sample; the bits below the
   // shift are random, since the codec throws them away.
   function automatic logic [SAMPLE_W-1:0] sample_of_value(int value);
      logic [17:0] low;
      low = 18'($urandom);
      return {value[13:0], low};
   endfunction

   // Picks a magnitude from one random segment so that all segments are hit
   // evenly. Now and then the magnitude that lies in no segment is used.
   function automatic logic [SAMPLE_W-1:0] segment_sample();
      int seg_low [8] = '{0, 31, 95, 223, 479, 991, 2015, 4063};
      int seg_high [8] = '{30, 94, 222, 478, 990, 2014, 4062, 8190};
      int seg;
      int mag;
      seg = $urandom_range(0, 7);
      mag = ($urandom_range(0, 31) == 0) ? 8191 : $urandom_range(seg_low[seg], seg_high[seg]);
      return sample_of_value($urandom_range(0, 1) ? -mag - 1 : mag);
   endfunction

   // Sends one request after a gap of the given length. It is called and returns
   // just after rising clock edges, and it returns once the request is accepted.
   // With no gap, start simply stays high for the next request.
   task automatic send_request(input action_type act, input logic [SAMPLE_W-1:0] smp,
                               input logic [CODE_W-1:0] code, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_sample_in <= smp;
      req_code_in   <= code;
      do @(posedge clock); while (busy);
   endtask

   task automatic encode_value(input int value);
      send_request(ACT_ENCODE, sample_of_value(value), 8'($urandom), $urandom_range(0, 3));
   endtask

   task automatic decode_byte(input logic [CODE_W-1:0] code);
      send_request(ACT_DECODE, $urandom, code, $urandom_range(0, 3));
   endtask

   initial begin
      int gap;
      int kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Zero and minus one are the smallest magnitudes of each
      // sign; the pairs around 30, 94 and 4062 cross segment borders.
      encode_value(0);
      encode_value(-1);
      encode_value(30);
      encode_value(31);
      encode_value(94);
      encode_value(95);
      encode_value(4062);
      encode_value(4063);
      encode_value(8190);
      encode_value(-31);
      encode_value(-32);
      encode_value(-8191);
      // The largest positive sample gives magnitude 8191, which is in no
      // segment and yields the sign bit alone; the most negative sample does
      // the same with the sign clear.
      send_request(ACT_ENCODE, 32'h7fff_ffff, 8'h00, 0);
      send_request(ACT_ENCODE, 32'h8000_0000, 8'hff, 0);
      encode_value(8191);
      encode_value(-8192);
      // Decode of the extreme codes: both signs, the first and last segment,
      // the first and last interval.
      decode_byte(8'h00);
      decode_byte(8'hff);
      decode_byte(8'h80);
      decode_byte(8'h7f);
      decode_byte(8'h0f);
      decode_byte(8'hf0);
      decode_byte(8'h8f);
      decode_byte(8'h70);

      // Random part. Every fifty requests the gap pattern changes: back to
      // back, fully random gaps, or rare gaps.
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         case ((i / 50) % 3)
            0: begin
               gap = 0;
            end
            1: begin
               gap = $urandom_range(0, 18);
            end
            default: begin
               gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
            end
         endcase

         // Halfway through, the sender holds off until every result is in.
         if (i == RANDOM_COUNT / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_results != 0) @(posedge clock);
            gap = 0;
         end

         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            send_request(ACT_ENCODE, segment_sample(), 8'($urandom), gap);
         end else if (kind <= 5) begin
            send_request(ACT_ENCODE, $urandom, 8'($urandom), gap);
         end else begin
            send_request(ACT_DECODE, $urandom, 8'($urandom), gap);
         end
      end
      start <= 1'b0;

      // Let every result arrive, then watch a little longer for strays.
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      // A result still owed at the end counts as a failure too.
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
